// ----- design/mvfa_pkg.sv -----
// Shared types and constants for the motion vector field accumulator.
`default_nettype none

package mvfa_pkg;

  // Field widths
  localparam int OPCODE_W  = 2;
  localparam int SIZE_W    = 12;
  localparam int FRAC_W    = 4;
  localparam int COORD_W   = SIZE_W + FRAC_W;
  localparam int CELL_W    = 7;
  localparam int GAIN_W    = 8;
  localparam int VEL_W     = 24;
  localparam int DXY_W     = COORD_W + 1;
  localparam int PROD_W    = DXY_W + GAIN_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;

  // Operations carried on in_tuser
  typedef enum logic [OPCODE_W-1:0] {
    OP_MOTION = 2'd0,
    OP_VORTEX = 2'd1,
    OP_DAMP   = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DAMP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STRENGTH = 3'd4;

  // Configuration reset values
  localparam logic [SIZE_W-1:0] WIDTH_RST    = 12'd320;
  localparam logic [SIZE_W-1:0] HEIGHT_RST   = 12'd240;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 8'd24;
  localparam logic [GAIN_W-1:0] DAMP_RST     = 8'd243;
  localparam logic [GAIN_W-1:0] STRENGTH_RST = 8'd6;

  // Input payload, last field in the lowest bits
  typedef struct packed {
    logic [1:0]         pad;
    logic [CELL_W-1:0]  cell_row;
    logic [CELL_W-1:0]  cell_col;
    logic [COORD_W-1:0] curr_y;
    logic [COORD_W-1:0] curr_x;
    logic [COORD_W-1:0] prev_y;
    logic [COORD_W-1:0] prev_x;
  } in_data_t;

  localparam int IN_TDATA_W  = $bits(in_data_t);
  localparam int OUT_TDATA_W = 2 * VEL_W;

  // Controller states
  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_BIN    = 7'b0000100,
    S_WALK   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_RDWAIT = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// ----- design/motion_vector_field_accumulator.sv -----
// Top level: grid of velocity vectors in one RAM with read-modify-write walker.
//
//   channel | ports                        | transfer carries
//   --------+------------------------------+---------------------------------------
//   input   | in_tvalid/in_tready          | opcode, two points, cell (one op)
//   result  | out_tvalid/out_tready        | vel_x, vel_y of a read cell
//   config  | cfg_wr_en/cfg_index/cfg_wdata| one register write per cycle
//
// Motion waits on the bit-per-cycle binning divider before its single cell update.
// Vortex walks a 2*VORTEX_HALF square of cells and damp walks every cell, one cell per
// cycle through the single RAM read port. A read passes through S_READ and S_RDWAIT.
// After reset a clearing pass writes zeros to all GRID_SIZE^2 cells with in_tready low.
// A waiting result holds in the output register; only a read then stalls.
`default_nettype none

module motion_vector_field_accumulator #(
  parameter int GRID_SIZE   = 128,
  parameter int VORTEX_HALF = 5
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // prev_x, prev_y, curr_x, curr_y, cell_col, cell_row, zero pad
  input  wire logic [mvfa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  wire logic [mvfa_pkg::OPCODE_W-1:0]    in_tuser,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // vel_x, vel_y
  output      logic [mvfa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                             cfg_wr_en,
  input  wire logic [mvfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mvfa_pkg::CFG_W-1:0]       cfg_wdata
);

  import mvfa_pkg::*;

  localparam int IW    = $clog2(GRID_SIZE);
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = ((IW > CELL_W) ? IW : CELL_W) + 1;
  localparam int VN    = 2 * VORTEX_HALF;
  localparam int VW    = $clog2(VN);
  localparam int OW    = IW + VW + 2;
  localparam int DW    = 2 * VEL_W;
  localparam int MW    = VEL_W + GAIN_W + 1;

  // Helpers
  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] row,
                                               input logic [IW-1:0] col);
    return AW'(AW'(row) * AW'(GRID_SIZE) + AW'(col));
  endfunction

  function automatic logic [IW-1:0] clamp_in(input logic [CELL_W-1:0] v);
    return (CW'(v) > CW'(GRID_SIZE - 1)) ? IW'(GRID_SIZE - 1) : IW'(v);
  endfunction

  function automatic logic [IW-1:0] clamp_ix(input logic signed [OW-1:0] v);
    logic [IW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(OW'(GRID_SIZE - 1))) begin
      r = IW'(GRID_SIZE - 1);
    end else begin
      r = v[IW-1:0];
    end
    return r;
  endfunction

  // Q8 to Q4, round half away from zero
  function automatic logic signed [VEL_W-1:0] round_q8(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    mag = p[PROD_W-1] ? -p : p;
    q   = (mag + PROD_W'(8)) >> FRAC_W;
    return p[PROD_W-1] ? -VEL_W'(q) : VEL_W'(q);
  endfunction

  function automatic logic [VEL_W-1:0] sat_add(input logic signed [VEL_W-1:0] a,
                                               input logic signed [VEL_W-1:0] b);
    logic signed [VEL_W:0] s;
    logic [VEL_W-1:0]      r;
    s = {a[VEL_W-1], a} + {b[VEL_W-1], b};
    if (s[VEL_W] != s[VEL_W-1]) begin
      r = s[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      r = s[VEL_W-1:0];
    end
    return r;
  endfunction

  // v * f / 256, truncated toward zero
  function automatic logic [VEL_W-1:0] damp_one(input logic signed [VEL_W-1:0] v,
                                                input logic [GAIN_W-1:0] f);
    logic signed [MW-1:0] p;
    logic signed [MW-1:0] adj;
    p   = v * $signed({1'b0, f});
    adj = p + $signed({{(VEL_W+1){1'b0}}, {GAIN_W{p[MW-1]}}});
    return adj[GAIN_W+VEL_W-1:GAIN_W];
  endfunction

  // Configuration registers
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [GAIN_W-1:0] gain_r;
  logic [GAIN_W-1:0] damp_r;
  logic [GAIN_W-1:0] strength_r;

  // Control
  state_t            state_r;
  state_t            state_nxt;
  opcode_t           op_r;
  logic [AW-1:0]     walk_addr_r;
  logic [VW-1:0]     vi_r;
  logic [VW-1:0]     vj_r;
  logic              out_valid_r;
  logic [DW-1:0]     out_data_r;

  // Item registers
  logic signed [DXY_W-1:0]  dx_r;
  logic signed [DXY_W-1:0]  dy_r;
  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;
  logic [IW-1:0]            ccol_r;
  logic [IW-1:0]            crow_r;

  // Write stage
  logic                    p1_v_r;
  logic [AW-1:0]           p1_addr_r;
  logic [VEL_W-1:0]        p1_ax_r;
  logic [VEL_W-1:0]        p1_ay_r;
  logic                    p1_fwd_r;
  logic [DW-1:0]           p1_fwd_data_r;

  in_data_t                in_d;
  logic                    in_acc;
  logic                    bin_done;
  logic                    bin_done_y;
  logic [IW-1:0]           bin_col;
  logic [IW-1:0]           bin_row;
  logic                    walk_last;
  logic                    vi_last;
  logic                    issue_v;
  logic [AW-1:0]           issue_addr;
  logic [VEL_W-1:0]        issue_ax;
  logic [VEL_W-1:0]        issue_ay;
  logic                    rd_issue;
  logic                    ram_rd_en;
  logic [AW-1:0]           ram_rd_addr;
  logic [DW-1:0]           ram_rd_data;
  logic                    ram_wr_en;
  logic [AW-1:0]           ram_wr_addr;
  logic [DW-1:0]           ram_wr_data;
  logic [DW-1:0]           cur;
  logic [DW-1:0]           wr_val;
  logic signed [VW:0]      iv;
  logic signed [VW:0]      jv;
  logic signed [VW+9:0]    vprod_i;
  logic signed [VW+9:0]    vprod_j;
  logic [IW-1:0]           vcol;
  logic [IW-1:0]           vrow;

  assign in_d      = in_tdata;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RST;
      height_r   <= HEIGHT_RST;
      gain_r     <= GAIN_RST;
      damp_r     <= DAMP_RST;
      strength_r <= STRENGTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_WIDTH:    width_r    <= cfg_wdata;
        CFG_IDX_HEIGHT:   height_r   <= cfg_wdata;
        CFG_IDX_GAIN:     gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_IDX_DAMP:     damp_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_IDX_STRENGTH: strength_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Binning dividers, started on every input transfer
  mvfa_bin_div #(.GRID_SIZE(GRID_SIZE)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .pos   (in_d.curr_x),
    .size  (width_r),
    .done  (bin_done),
    .idx   (bin_col)
  );

  mvfa_bin_div #(.GRID_SIZE(GRID_SIZE)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .pos   (in_d.curr_y),
    .size  (height_r),
    .done  (bin_done_y),
    .idx   (bin_row)
  );

  // Capture the item; the displacement product settles while binning runs
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dx_r   <= $signed({1'b0, in_d.curr_x}) - $signed({1'b0, in_d.prev_x});
      dy_r   <= $signed({1'b0, in_d.curr_y}) - $signed({1'b0, in_d.prev_y});
      ccol_r <= clamp_in(in_d.cell_col);
      crow_r <= clamp_in(in_d.cell_row);
    end
    prod_x_r <= $signed({1'b0, gain_r}) * dx_r;
    prod_y_r <= $signed({1'b0, gain_r}) * dy_r;
  end

  // Vortex offsets and contributions
  assign iv      = $signed({1'b0, vi_r}) - $signed((VW+1)'(VORTEX_HALF));
  assign jv      = $signed({1'b0, vj_r}) - $signed((VW+1)'(VORTEX_HALF));
  assign vprod_i = iv * $signed({1'b0, strength_r});
  assign vprod_j = jv * $signed({1'b0, strength_r});
  assign vcol    = clamp_ix(OW'($signed({1'b0, ccol_r})) + OW'(iv));
  assign vrow    = clamp_ix(OW'($signed({1'b0, crow_r})) + OW'(jv));
  assign vi_last = (vi_r == VW'(VN - 1));

  // Issue one cell read per walk cycle
  always_comb begin
    issue_v    = 1'b0;
    issue_addr = walk_addr_r;
    issue_ax   = '0;
    issue_ay   = '0;
    walk_last  = 1'b0;
    if (state_r == S_WALK) begin
      issue_v = 1'b1;
      case (op_r)
        OP_MOTION: begin
          issue_addr = cell_addr(bin_row, bin_col);
          issue_ax   = round_q8(prod_x_r);
          issue_ay   = round_q8(prod_y_r);
          walk_last  = 1'b1;
        end
        OP_VORTEX: begin
          issue_addr = cell_addr(vrow, vcol);
          issue_ax   = VEL_W'(vprod_j);
          issue_ay   = -VEL_W'(vprod_i);
          walk_last  = vi_last && (vj_r == VW'(VN - 1));
        end
        OP_DAMP: begin
          walk_last = (walk_addr_r == AW'(CELLS - 1));
        end
        default: begin
          walk_last = 1'b1;
        end
      endcase
    end
  end

  assign rd_issue    = (state_r == S_READ) && !out_valid_r;
  assign ram_rd_en   = issue_v || rd_issue;
  assign ram_rd_addr = issue_v ? issue_addr : cell_addr(crow_r, ccol_r);

  // Modify: forwarded value wins when the previous write hit the same cell
  always_comb begin
    cur = p1_fwd_r ? p1_fwd_data_r : ram_rd_data;
    if (op_r == OP_DAMP) begin
      wr_val = {damp_one(cur[DW-1:VEL_W], damp_r), damp_one(cur[VEL_W-1:0], damp_r)};
    end else begin
      wr_val = {sat_add(cur[DW-1:VEL_W], p1_ay_r), sat_add(cur[VEL_W-1:0], p1_ax_r)};
    end
  end

  // Write port: zeros during the clearing pass, else the write stage
  assign ram_wr_en   = (state_r == S_CLEAR) || p1_v_r;
  assign ram_wr_addr = (state_r == S_CLEAR) ? walk_addr_r : p1_addr_r;
  assign ram_wr_data = (state_r == S_CLEAR) ? '0 : wr_val;

  mvfa_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_field_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Advance the write stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r   <= 1'b0;
      p1_fwd_r <= 1'b0;
    end else begin
      p1_v_r   <= issue_v;
      p1_fwd_r <= issue_v && p1_v_r && (issue_addr == p1_addr_r);
    end
    p1_addr_r     <= issue_addr;
    p1_ax_r       <= issue_ax;
    p1_ay_r       <= issue_ay;
    p1_fwd_data_r <= wr_val;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (walk_addr_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (opcode_t'(in_tuser))
            OP_MOTION: state_nxt = S_BIN;
            OP_VORTEX: state_nxt = S_WALK;
            OP_DAMP:   state_nxt = S_WALK;
            default:   state_nxt = S_READ;
          endcase
        end
      end
      S_BIN: begin
        if (bin_done && bin_done_y) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_IDLE;
      S_READ: begin
        if (rd_issue) begin
          state_nxt = S_RDWAIT;
        end
      end
      S_RDWAIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control registers: state, walk counters, result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      op_r        <= OP_READ;
      walk_addr_r <= '0;
      vi_r        <= '0;
      vj_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        op_r <= opcode_t'(in_tuser);
        vi_r <= '0;
        vj_r <= '0;
      end
      // Sweep the cell counter for clearing and damping
      if ((state_r == S_CLEAR) || ((state_r == S_WALK) && (op_r == OP_DAMP))) begin
        walk_addr_r <= (walk_addr_r == AW'(CELLS - 1)) ? '0 : walk_addr_r + AW'(1);
      end
      // Step through the vortex square, columns inner
      if ((state_r == S_WALK) && (op_r == OP_VORTEX)) begin
        vi_r <= vi_last ? '0 : vi_r + VW'(1);
        if (vi_last) begin
          vj_r <= vj_r + VW'(1);
        end
      end
      // Hold the result until its transfer
      if (state_r == S_RDWAIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RDWAIT) begin
      out_data_r <= ram_rd_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/mvfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mvfa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- design/mvfa_bin_div.sv -----
// Restoring divider that bins one coordinate into a clamped grid index.
`default_nettype none

module mvfa_bin_div #(
  parameter int GRID_SIZE = 128
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [mvfa_pkg::COORD_W-1:0] pos,
  input  wire logic [mvfa_pkg::SIZE_W-1:0]  size,
  output      logic                         done,
  output      logic [$clog2(GRID_SIZE)-1:0] idx
);

  import mvfa_pkg::*;

  localparam int IW   = $clog2(GRID_SIZE);
  localparam int NW   = COORD_W + IW;
  localparam int CNTW = $clog2(IW + 1);

  logic [NW-1:0]      rem_r;
  logic [NW-1:0]      dsh_r;
  logic [IW-1:0]      q_r;
  logic               over_r;
  logic [CNTW-1:0]    cnt_r;
  logic [COORD_W-1:0] dvs;
  logic               ge;

  // Divisor is the image size in Q4, a zero size counts as one pixel
  assign dvs  = {((size == '0) ? SIZE_W'(1) : size), {FRAC_W{1'b0}}};
  assign ge   = (rem_r >= dsh_r);
  assign done = (cnt_r == CNTW'(IW));
  assign idx  = over_r ? IW'(GRID_SIZE - 1) : q_r;

  // Step counter, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNTW'(IW);
    end else if (start) begin
      cnt_r <= '0;
    end else if (!done) begin
      cnt_r <= cnt_r + CNTW'(1);
    end
  end

  // Shift-subtract datapath; a position past the image clamps to the last cell
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= NW'(pos) * NW'(GRID_SIZE);
      dsh_r  <= NW'(dvs) << (IW - 1);
      q_r    <= '0;
      over_r <= (pos >= dvs);
    end else if (!done) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= (q_r << 1) | IW'(ge);
    end
  end

endmodule

`default_nettype wire

// ----- sim/mvfa_read_checker.sv -----
// Read-result checker for the motion vector field accumulator: predicts the grid and compares reads.
`timescale 1ns / 100ps

module mvfa_read_checker #(
  parameter int GRID_SIZE   = 128,
  parameter int VORTEX_HALF = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // prev_x, prev_y, curr_x, curr_y, cell_col, cell_row, zero pad
  input  logic [mvfa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [mvfa_pkg::OPCODE_W-1:0]    in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // vel_x, vel_y
  input  logic [mvfa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [mvfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mvfa_pkg::CFG_W-1:0]       cfg_wdata,
  output int                               mismatches,
  output int                               reads_pending
);
  import mvfa_pkg::*;

  localparam int     CELLS   = GRID_SIZE * GRID_SIZE;
  localparam longint VEL_MAX = (longint'(1) << (VEL_W - 1)) - 1;
  localparam longint VEL_MIN = -(longint'(1) << (VEL_W - 1));

  // One cell as it leaves on out_tdata, vel_x in the low half
  typedef struct packed {
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_x;
  } velocity_t;

  logic signed [VEL_W-1:0] grid_vx [CELLS];
  logic signed [VEL_W-1:0] grid_vy [CELLS];
  logic [SIZE_W-1:0]       img_width;
  logic [SIZE_W-1:0]       img_height;
  logic [GAIN_W-1:0]       gain_q4;
  logic [GAIN_W-1:0]       damp_q8;
  logic [GAIN_W-1:0]       swirl_q4;
  velocity_t               cell_reads_due [$];
  int                      fail_total = 0;

  function automatic logic signed [VEL_W-1:0] clip_vel(longint v);
    if (v > VEL_MAX) return VEL_W'(VEL_MAX);
    if (v < VEL_MIN) return VEL_W'(VEL_MIN);
    return VEL_W'(v);
  endfunction

  // Q8 product down to Q4, ties away from zero
  function automatic longint scaled_displacement(longint prod);
    longint mag;
    mag = (prod < 0) ? -prod : prod;
    mag = (mag + 8) >>> 4;
    return (prod < 0) ? -mag : mag;
  endfunction

  // Scale by a Q8 factor, truncating toward zero
  function automatic logic signed [VEL_W-1:0] damped(logic signed [VEL_W-1:0] v,
                                                     logic [GAIN_W-1:0] factor);
    longint p;
    longint mag;
    p   = longint'(v) * longint'(factor);
    mag = ((p < 0) ? -p : p) >>> 8;
    return clip_vel((p < 0) ? -mag : mag);
  endfunction

  function automatic int grid_bin(longint pos, logic [SIZE_W-1:0] size);
    longint span;
    longint c;
    span = (size == 0) ? longint'(1) : longint'(size);
    c    = (pos * GRID_SIZE) / (span * 16);
    if (c > GRID_SIZE - 1) c = GRID_SIZE - 1;
    return int'(c);
  endfunction

  function automatic int clamp_index(longint v);
    if (v < 0) return 0;
    if (v > GRID_SIZE - 1) return GRID_SIZE - 1;
    return int'(v);
  endfunction

  task automatic accumulate(input int row, input int col, input longint ax, input longint ay);
    int k;
    k = row * GRID_SIZE + col;
    grid_vx[k] = clip_vel(longint'(grid_vx[k]) + ax);
    grid_vy[k] = clip_vel(longint'(grid_vy[k]) + ay);
  endtask

  // Advance the predicted grid by one accepted operation
  task automatic apply_op(input opcode_t op, input in_data_t d);
    longint    dx;
    longint    dy;
    int        ccol;
    int        crow;
    velocity_t v;
    ccol = clamp_index(longint'(d.cell_col));
    crow = clamp_index(longint'(d.cell_row));
    case (op)
      OP_MOTION: begin
        dx = longint'(d.curr_x) - longint'(d.prev_x);
        dy = longint'(d.curr_y) - longint'(d.prev_y);
        accumulate(grid_bin(longint'(d.curr_y), img_height),
                   grid_bin(longint'(d.curr_x), img_width),
                   scaled_displacement(dx * longint'(gain_q4)),
                   scaled_displacement(dy * longint'(gain_q4)));
      end
      OP_VORTEX: begin
        for (int j = -VORTEX_HALF; j < VORTEX_HALF; j++) begin
          for (int i = -VORTEX_HALF; i < VORTEX_HALF; i++) begin
            accumulate(clamp_index(longint'(crow + j)), clamp_index(longint'(ccol + i)),
                       longint'(j) * longint'(swirl_q4), -longint'(i) * longint'(swirl_q4));
          end
        end
      end
      OP_DAMP: begin
        for (int k = 0; k < CELLS; k++) begin
          grid_vx[k] = damped(grid_vx[k], damp_q8);
          grid_vy[k] = damped(grid_vy[k], damp_q8);
        end
      end
      OP_READ: begin
        v.vel_x = grid_vx[crow * GRID_SIZE + ccol];
        v.vel_y = grid_vy[crow * GRID_SIZE + ccol];
        cell_reads_due = {cell_reads_due, v};
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    velocity_t got;
    velocity_t want;
    if (!rst_n) begin
      for (int k = 0; k < CELLS; k++) begin
        grid_vx[k] = '0;
        grid_vy[k] = '0;
      end
      img_width  = WIDTH_RST;
      img_height = HEIGHT_RST;
      gain_q4    = GAIN_RST;
      damp_q8    = DAMP_RST;
      swirl_q4   = STRENGTH_RST;
      cell_reads_due.delete();
    end else begin
      // Register writes; indexes past the last register are dropped
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IDX_WIDTH:    img_width  = cfg_wdata[SIZE_W-1:0];
          CFG_IDX_HEIGHT:   img_height = cfg_wdata[SIZE_W-1:0];
          CFG_IDX_GAIN:     gain_q4    = cfg_wdata[GAIN_W-1:0];
          CFG_IDX_DAMP:     damp_q8    = cfg_wdata[GAIN_W-1:0];
          CFG_IDX_STRENGTH: swirl_q4   = cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      // Compare a result transfer against the oldest predicted read
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (cell_reads_due.size() == 0) begin
          if (fail_total < 10)
            $display("%0t: unexpected read result vel_x %0d vel_y %0d",
                     $realtime, got.vel_x, got.vel_y);
          fail_total++;
        end else begin
          want = cell_reads_due.pop_front();
          if (got.vel_x !== want.vel_x || got.vel_y !== want.vel_y) begin
            if (fail_total < 10)
              $display("%0t: read mismatch: vel_x exp %0d got %0d, vel_y exp %0d got %0d",
                       $realtime, want.vel_x, got.vel_x, want.vel_y, got.vel_y);
            fail_total++;
          end
        end
      end

      if (in_tvalid && in_tready) apply_op(opcode_t'(in_tuser), in_data_t'(in_tdata));
    end
    mismatches    <= fail_total;
    reads_pending <= cell_reads_due.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the motion vector field accumulator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import mvfa_pkg::*;

  localparam int GRID_SIZE    = 128;
  localparam int VORTEX_HALF  = 5;
  localparam int DRAIN_CYCLES = GRID_SIZE * GRID_SIZE + 64;
  localparam int DAMP_BUDGET  = 12;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  in_data_t               in_tdata   = '0;
  opcode_t                in_tuser   = OP_MOTION;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = CFG_IDX_WIDTH;
  logic [CFG_W-1:0]       cfg_wdata  = '0;
  int                     mismatches;
  int                     reads_pending;

  logic                   gaps_on    = 1'b1;
  int                     damps_left = DAMP_BUDGET;
  logic [SIZE_W-1:0]      cur_width  = WIDTH_RST;
  logic [SIZE_W-1:0]      cur_height = HEIGHT_RST;

  always #1 clk = ~clk;

  motion_vector_field_accumulator #(
    .GRID_SIZE  (GRID_SIZE),
    .VORTEX_HALF(VORTEX_HALF)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mvfa_read_checker #(
    .GRID_SIZE  (GRID_SIZE),
    .VORTEX_HALF(VORTEX_HALF)
  ) read_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .reads_pending(reads_pending)
  );

  // Hard stop well past the slowest legal run
  initial begin
    #4_000_000;
    $display("motion_vector_field_accumulator verification failed");
    $finish;
  end

  // Result side: stall in short random bursts while gaps are on
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (gaps_on && stall_left == 0 && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic in_data_t make_payload(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                            logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                            logic [CELL_W-1:0] col, logic [CELL_W-1:0] row);
    in_data_t d;
    d          = '0;
    d.prev_x   = px;
    d.prev_y   = py;
    d.curr_x   = cx;
    d.curr_y   = cy;
    d.cell_col = col;
    d.cell_row = row;
    return d;
  endfunction

  // Cells at both grid edges and the middle, where reads and writes meet often
  function automatic logic [CELL_W-1:0] hot_cell();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 63;
      4:       return 64;
      5:       return 125;
      6:       return 126;
      default: return 127;
    endcase
  endfunction

  // Q4 pixel position that bins into or next to the given cell
  function automatic logic [COORD_W-1:0] coord_near(logic [CELL_W-1:0] target,
                                                    logic [SIZE_W-1:0] size);
    longint span;
    longint pos;
    span = (size == 0) ? longint'(16) : longint'(size) * 16;
    pos  = (longint'(target) * span + longint'($urandom_range(0, int'(span) - 1))) / GRID_SIZE;
    if (pos > 65535) pos = 65535;
    return pos[COORD_W-1:0];
  endfunction

  // Previous position: small steps, rounding ties, long jumps and the extremes
  function automatic logic [COORD_W-1:0] prev_from(logic [COORD_W-1:0] curr);
    longint p;
    case ($urandom_range(0, 4))
      0:       p = longint'(curr) + longint'($urandom_range(0, 64)) - 32;
      1:       p = longint'(curr) + longint'($urandom_range(0, 4096)) - 2048;
      2:       p = longint'($urandom_range(0, 65535));
      3:       p = $urandom_range(0, 1) ? longint'(0) : longint'(65535);
      default: p = longint'(curr) + ($urandom_range(0, 1) ? longint'(1) : longint'(-1));
    endcase
    if (p < 0) p = 0;
    if (p > 65535) p = 65535;
    return p[COORD_W-1:0];
  endfunction

  // Hold one item on the input until it transfers, then maybe leave a gap
  task automatic send_item(input opcode_t op, input in_data_t d);
    in_tuser  <= op;
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    in_data_t d;
    opcode_t  op;
    int       pick;
    d = make_payload(COORD_W'($urandom_range(0, 65535)), COORD_W'($urandom_range(0, 65535)),
                     COORD_W'($urandom_range(0, 65535)), COORD_W'($urandom_range(0, 65535)),
                     CELL_W'($urandom_range(0, 127)), CELL_W'($urandom_range(0, 127)));
    pick = $urandom_range(0, 99);
    if (pick < 45)                         op = OP_MOTION;
    else if (pick < 57)                    op = OP_VORTEX;
    else if (pick == 57 && damps_left > 0) op = OP_DAMP;
    else                                   op = OP_READ;
    // Mostly aim at the hot cells; the rest stays fully random
    case (op)
      OP_MOTION: begin
        if ($urandom_range(0, 4) != 0) begin
          d.curr_x = coord_near(hot_cell(), cur_width);
          d.curr_y = coord_near(hot_cell(), cur_height);
          d.prev_x = prev_from(d.curr_x);
          d.prev_y = prev_from(d.curr_y);
        end
      end
      OP_VORTEX, OP_READ: begin
        if ($urandom_range(0, 9) < 7) begin
          d.cell_col = hot_cell();
          d.cell_row = hot_cell();
        end
      end
      OP_DAMP: damps_left--;
      default: ;
    endcase
    send_item(op, d);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      // Now and then hold off until every read has come back
      if (gaps_on && $urandom_range(0, 49) == 0) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (reads_pending != 0);
      end
      send_random_item();
    end
  endtask

  // Drain all reads, then let the longest walk finish
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (reads_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Unused indexes first, then every register; 8-bit registers get junk upper bits
  task automatic program_regs(input logic [SIZE_W-1:0] width, input logic [SIZE_W-1:0] height,
                              input logic [GAIN_W-1:0] gain, input logic [GAIN_W-1:0] damping,
                              input logic [GAIN_W-1:0] strength);
    for (int n = 0; n < 3; n++)
      write_reg(CFG_IDX_W'(CFG_IDX_STRENGTH + 1 + n), CFG_W'($urandom));
    write_reg(CFG_IDX_WIDTH, width);
    write_reg(CFG_IDX_HEIGHT, height);
    write_reg(CFG_IDX_GAIN, {4'($urandom), gain});
    write_reg(CFG_IDX_DAMP, {4'($urandom), damping});
    write_reg(CFG_IDX_STRENGTH, {4'($urandom), strength});
    cfg_wr_en  <= 1'b0;
    cur_width  = width;
    cur_height = height;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: field extremes, rounding ties, edge vortices, damp, ignored fields
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 0, 0));
    send_item(OP_MOTION, make_payload(0, 0, 0, 0, 0, 0));
    send_item(OP_MOTION, make_payload(0, 0, 16'hFFFF, 16'hFFFF, 0, 0));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 127, 127));
    send_item(OP_MOTION, make_payload(16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 0, 0));
    send_item(OP_MOTION, make_payload(100, 100, 101, 99, 0, 0));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 2, 3));
    send_item(OP_VORTEX, make_payload(0, 0, 0, 0, 0, 0));
    send_item(OP_VORTEX, make_payload(0, 0, 0, 0, 127, 127));
    send_item(OP_VORTEX, make_payload(0, 0, 0, 0, 64, 63));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 0, 0));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 127, 127));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 64, 63));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 59, 58));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 68, 67));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 4, 4));
    send_item(OP_DAMP,   make_payload(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 127, 127));
    send_item(OP_READ,   make_payload(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 127, 127));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 64, 63));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 127, 0));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 0, 127));
    settle();

    // Top settings: drive two corner cells into saturation both ways
    program_regs(4095, 1, 255, 255, 255);
    for (int n = 0; n < 10; n++) begin
      send_item(OP_MOTION, make_payload(0, 0, 16'hFFFF, 16'hFFFF, 0, 0));
      send_item(OP_MOTION, make_payload(16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
    end
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 127, 127));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 0, 0));
    send_item(OP_VORTEX, make_payload(0, 0, 0, 0, 127, 127));
    send_item(OP_VORTEX, make_payload(0, 0, 0, 0, 0, 0));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 127, 127));
    send_item(OP_READ,   make_payload(0, 0, 0, 0, 0, 0));
    run_random(120);
    settle();

    // Zero image size and zero gains, no idling
    gaps_on = 1'b0;
    program_regs(0, 0, 0, 0, 0);
    run_random(80);
    settle();

    gaps_on = 1'b1;
    program_regs(1, 4095, 255, 1, 1);
    run_random(150);
    settle();

    program_regs(SIZE_W'($urandom_range(1, 4095)), SIZE_W'($urandom_range(1, 4095)),
                 GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(0, 255)),
                 GAIN_W'($urandom_range(0, 255)));
    run_random(180);
    settle();

    program_regs(SIZE_W'($urandom_range(1, 400)), SIZE_W'($urandom_range(1, 400)),
                 GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(200, 255)),
                 GAIN_W'($urandom_range(0, 255)));
    run_random(180);
    settle();

    // Closing stretch without idling on either side
    gaps_on = 1'b0;
    program_regs(SIZE_W'($urandom_range(1, 4095)), SIZE_W'($urandom_range(1, 4095)),
                 GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(0, 255)),
                 GAIN_W'($urandom_range(0, 255)));
    run_random(180);
    settle();

    if (mismatches == 0 && reads_pending == 0) begin
      $display("motion_vector_field_accumulator verification clean");
    end else begin
      $display("motion_vector_field_accumulator verification failed");
    end
    $finish;
  end

endmodule
